@@ hw/rtl/lwrp_pkg.sv @@
`default_nettype none
package lwrp_pkg;

    // command codes
    localparam logic [1:0] CMD_TIME = 2'd0;
    localparam logic [1:0] CMD_PICK = 2'd1;
    localparam logic [1:0] CMD_DOCS = 2'd2;

    // configuration register indexes
    localparam logic CFG_DECAY = 1'b0;
    localparam logic CFG_INIT  = 1'b1;

    // fixed widths of the fields
    localparam int TIME_W  = 32;
    localparam int QC_W    = 16;
    localparam int WT_W    = 26;   // 2^32 / 66 fits in 26 bits
    localparam int DOCS_W  = 40;
    localparam int TOTAL_W = 43;
    localparam int FRAC_W  = 16;

    localparam logic [QC_W-1:0]   MIN_DIV  = 16'd42;
    localparam logic [TIME_W-1:0] MIN_TIME = 32'd66;
    localparam logic [QC_W-1:0]   QC_MAX   = 16'hFFFF;
    localparam logic [7:0]        INV_MAX  = 8'hFF;

    // shared divider: 49-bit dividend, 32-bit divisor, one quotient bit a cycle
    localparam int DIV_NW    = 49;
    localparam int DIV_DW    = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NW + 1);
    localparam logic [DIV_NW-1:0] DIV_ONE = 49'h1_0000_0000;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quot;
    } t_div_rsp;

    // one entry of the timing memory
    typedef struct packed {
        logic [TIME_W-1:0] avg;
        logic [QC_W-1:0]   qc;
        logic [WT_W-1:0]   wt;
    } t_trow;

endpackage
`default_nettype wire

@@ hw/rtl/lwrp_ram.sv @@
`default_nettype none
module lwrp_ram #(
    parameter int W = 8,
    parameter int D = 8
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire [W-1:0]                  i_wdata,
    input  wire                          i_re,
    input  wire [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                 o_rdata
);
    logic [W-1:0] r_mem [D];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/lwrp_div.sv @@
`default_nettype none
module lwrp_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  lwrp_pkg::t_div_req i_req,
    output lwrp_pkg::t_div_rsp o_rsp
);
    import lwrp_pkg::*;

    logic [DIV_DW-1:0]    r_rem;
    logic [DIV_NW-1:0]    r_num;
    logic [DIV_DW-1:0]    r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;

    logic [DIV_DW:0]   sh;
    logic [DIV_DW+1:0] diff;
    logic              qbit;

    // restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        sh   = {r_rem, r_num[DIV_NW-1]};
        diff = {1'b0, sh} - {2'b00, r_den};
        qbit = ~diff[DIV_DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_run) begin
                r_rem <= qbit ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
                r_num <= {r_num[DIV_NW-2:0], qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_rem <= '0;
                r_num <= i_req.num;
                r_den <= i_req.den;
                r_cnt <= DIV_CNT_W'(DIV_NW);
                r_run <= 1'b1;
            end
        end
    end

    assign o_rsp.busy = r_run;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num[DIV_DW-1:0];
endmodule
`default_nettype wire

@@ hw/rtl/latency_weighted_row_picker.sv @@
`default_nettype none
// Row picker weighted by inverse response time.
// A command word is taken at a rising edge with start high and busy low.
// Command 0 folds a response-time sample into one row's decaying average,
// command 1 picks a row at random by inverse-average weight using
// i_pick_fraction, command 2 moves one row's active document count.
// Every word gives one result, held on the o_ ports for one cycle while
// o_valid is high; the receiver cannot stall, so it must take it then.
// Order of work after the accepting edge:
// a time update reads the row, then runs the shared bit-serial divider twice
// (new average, then new weight 2^32/average).
// A pick makes one sweep of the timing memory for the weight sum and one for
// the cumulative search, which stops at the first hit. A docs update writes
// the row's count. Every command ends with a sweep of the docs memory for the
// largest row count, then raises o_valid. One word at a time.
// After reset, and after every write of initial_time, busy stays high while the
// default weight is computed; row entries read as their reset values until
// first written (valid bits, no clearing pass).
// Configuration is a plain write port; write only while busy is low.
module latency_weighted_row_picker #(
    parameter int NUM_ROWS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [1:0]   i_command,
    input  wire [2:0]   i_row,
    input  wire [31:0]  i_sample_time,
    input  wire [15:0]  i_pick_fraction,
    input  wire [39:0]  i_new_count,
    input  wire         i_new_valid,
    input  wire [39:0]  i_old_count,
    input  wire         i_old_valid,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire [31:0]  i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_chosen_row,
    output logic [39:0] o_max_active_docs,
    output logic        o_docs_valid,
    output logic [42:0] o_total_active_docs
);
    import lwrp_pkg::*;

    localparam int RW = NUM_ROWS > 1 ? $clog2(NUM_ROWS) : 1;
    localparam int CW = RW + 1;
    localparam int SW = WT_W + $clog2(NUM_ROWS);
    localparam int PW = FRAC_W + SW;
    localparam logic [CW-1:0] CNT_N = CW'(NUM_ROWS);
    localparam logic [RW-1:0] LAST  = RW'(NUM_ROWS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INITW = 4'd1;
    localparam logic [3:0] S_TRD   = 4'd2;
    localparam logic [3:0] S_TMUL  = 4'd3;
    localparam logic [3:0] S_TDIV  = 4'd4;
    localparam logic [3:0] S_TDIVW = 4'd5;
    localparam logic [3:0] S_TWTW  = 4'd6;
    localparam logic [3:0] S_DRD   = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_PMUL  = 4'd9;
    localparam logic [3:0] S_PICK  = 4'd10;
    localparam logic [3:0] S_MAX   = 4'd11;

    // control and configuration
    logic [3:0]          r_state;
    logic                r_stale;
    logic [QC_W-1:0]     r_decay;
    logic [TIME_W-1:0]   r_init;
    logic [WT_W-1:0]     r_def_wt;
    logic [NUM_ROWS-1:0] r_tval;
    logic [NUM_ROWS-1:0] r_dval;
    logic                r_tv_q;
    logic                r_dv_q;
    logic [TOTAL_W-1:0]  r_total;
    logic [7:0]          r_inv;

    // latched word
    logic [1:0]          r_cmd;
    logic [RW-1:0]       r_raddr;
    logic [TIME_W-1:0]   r_samp;
    logic [FRAC_W-1:0]   r_frac;
    logic [DOCS_W-1:0]   r_nc;
    logic [DOCS_W-1:0]   r_oc;
    logic                r_nv;
    logic                r_ov;

    // working registers
    logic [TIME_W-1:0]   r_avg;
    logic [QC_W-1:0]     r_qc;
    logic [QC_W-1:0]     r_d;
    logic [47:0]         r_tprod;
    logic [TIME_W-1:0]   r_newavg;
    logic [SW-1:0]       r_sum;
    logic [SW-1:0]       r_acc;
    logic [PW-1:0]       r_pprod;
    logic [CW-1:0]       r_cnt;
    logic [RW-1:0]       r_ridx;
    logic                r_pend;
    logic [RW-1:0]       r_chosen;
    logic [DOCS_W-1:0]   r_max;

    // memory ports
    logic                t_we, t_re, d_we, d_re;
    logic [RW-1:0]       t_raddr, d_raddr;
    t_trow               t_wdata, t_q;
    logic [DOCS_W-1:0]   d_wdata, d_q;
    logic [$bits(t_trow)-1:0] t_q_raw;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic                accept;
    logic                in_range;
    logic [RW+2:0]       row_x;
    logic [RW-1:0]       row_addr;
    logic [TIME_W-1:0]   def_avg;
    logic [QC_W-1:0]     lim;
    logic [QC_W:0]       dq;
    logic                issue;
    logic [RW-1:0]       sw_addr;
    logic [TIME_W-1:0]   avg_eff;
    logic [QC_W-1:0]     qc_eff;
    logic [WT_W-1:0]     wt_eff;
    logic [DOCS_W-1:0]   docs_eff;
    logic [SW-1:0]       acc_n;
    logic                hit;
    logic [DOCS_W-1:0]   max_n;
    logic [RW+2:0]       chosen_x;

    assign busy   = (r_state != S_IDLE) | r_stale;
    assign accept = start & ~busy;

    // derived values
    always_comb begin
        row_x    = (RW + 3)'(i_row);
        row_addr = row_x[RW-1:0];
        in_range = 32'(i_row) < NUM_ROWS;
        def_avg  = (r_init < MIN_TIME) ? MIN_TIME : r_init;
        lim      = (r_decay < MIN_DIV) ? MIN_DIV : r_decay;
        issue    = r_cnt < CNT_N;
        sw_addr  = r_cnt[RW-1:0];
        t_q      = t_q_raw;
        avg_eff  = r_tv_q ? t_q.avg : def_avg;
        qc_eff   = r_tv_q ? t_q.qc : '0;
        wt_eff   = r_tv_q ? t_q.wt : r_def_wt;
        docs_eff = r_dv_q ? d_q : '0;
        dq       = {1'b0, qc_eff} + {1'b0, MIN_DIV};
        acc_n    = r_acc + SW'(wt_eff);
        hit      = r_pprod < {acc_n, 16'h0000};
        max_n    = (docs_eff > r_max) ? docs_eff : r_max;
        chosen_x = (RW + 3)'(r_chosen);
    end

    // memory and divider requests
    always_comb begin
        t_we    = 1'b0;
        t_re    = 1'b0;
        t_raddr = r_raddr;
        t_wdata = '0;
        d_we    = 1'b0;
        d_re    = 1'b0;
        d_raddr = r_raddr;
        d_wdata = docs_eff + r_nc - r_oc;
        div_req = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    t_raddr = row_addr;
                    d_raddr = row_addr;
                    t_re    = (i_command == CMD_TIME) & in_range;
                    d_re    = (i_command == CMD_DOCS) & in_range;
                end else if (r_stale) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_ONE;
                    div_req.den   = def_avg;
                end
            end
            S_TDIV: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(r_tprod) + DIV_NW'(r_samp);
                div_req.den   = DIV_DW'(r_d);
            end
            S_TDIVW: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_ONE;
                    div_req.den   = div_rsp.quot;
                end
            end
            S_TWTW: begin
                if (div_rsp.done) begin
                    t_we       = 1'b1;
                    t_wdata.avg = r_newavg;
                    t_wdata.qc  = (r_qc < QC_MAX) ? r_qc + 1'b1 : r_qc;
                    t_wdata.wt  = div_rsp.quot[WT_W-1:0];
                end
            end
            S_DRD: begin
                d_we = 1'b1;
            end
            S_SUM, S_PICK: begin
                t_re    = issue;
                t_raddr = sw_addr;
            end
            S_MAX: begin
                d_re    = issue;
                d_raddr = sw_addr;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stale <= 1'b1;
            r_decay <= 16'd1000;
            r_init  <= 32'd65536;
            r_tval  <= '0;
            r_dval  <= '0;
            r_total <= '0;
            r_inv   <= '0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (t_re) begin
                r_tv_q <= r_tval[t_raddr];
            end
            if (d_re) begin
                r_dv_q <= r_dval[d_raddr];
            end
            if (t_we) begin
                r_tval[r_raddr] <= 1'b1;
            end
            if (d_we) begin
                r_dval[r_raddr] <= 1'b1;
            end
            // sweep address and return tracking
            if (r_state == S_SUM || r_state == S_PICK || r_state == S_MAX) begin
                if (issue) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_ridx <= sw_addr;
                end
                r_pend <= issue;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_command;
                        r_raddr  <= row_addr;
                        r_samp   <= (i_sample_time < MIN_TIME) ? MIN_TIME : i_sample_time;
                        r_frac   <= i_pick_fraction;
                        r_nc     <= i_new_count;
                        r_oc     <= i_old_count;
                        r_nv     <= i_new_valid;
                        r_ov     <= i_old_valid;
                        r_cnt    <= '0;
                        r_pend   <= 1'b0;
                        r_max    <= '0;
                        r_chosen <= '0;
                        r_sum    <= '0;
                        r_acc    <= '0;
                        case (i_command)
                            CMD_TIME: r_state <= in_range ? S_TRD : S_MAX;
                            CMD_PICK: r_state <= S_SUM;
                            CMD_DOCS: r_state <= in_range ? S_DRD : S_MAX;
                            default:  r_state <= S_MAX;
                        endcase
                    end else if (r_stale) begin
                        r_stale <= 1'b0;
                        r_state <= S_INITW;
                    end
                end
                S_INITW: begin
                    if (div_rsp.done) begin
                        r_def_wt <= div_rsp.quot[WT_W-1:0];
                        r_state  <= S_IDLE;
                    end
                end
                // time update: divisor, product, two divides
                S_TRD: begin
                    r_avg   <= avg_eff;
                    r_qc    <= qc_eff;
                    r_d     <= (dq > {1'b0, lim}) ? lim : dq[QC_W-1:0];
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_tprod <= 48'(r_d - 1'b1) * 48'(r_avg);
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    r_state <= S_TDIVW;
                end
                S_TDIVW: begin
                    if (div_rsp.done) begin
                        r_newavg <= div_rsp.quot;
                        r_state  <= S_TWTW;
                    end
                end
                S_TWTW: begin
                    if (div_rsp.done) begin
                        r_state <= S_MAX;
                    end
                end
                // docs update
                S_DRD: begin
                    r_total <= r_total + TOTAL_W'(r_nc) - TOTAL_W'(r_oc);
                    if (r_nv != r_ov) begin
                        if (r_ov) begin
                            if (r_inv < INV_MAX) r_inv <= r_inv + 1'b1;
                        end else if (r_inv != 8'd0) begin
                            r_inv <= r_inv - 1'b1;
                        end
                    end
                    r_state <= S_MAX;
                end
                // pick: weight sum, then cumulative search
                S_SUM: begin
                    if (r_pend) begin
                        r_sum <= acc_n;
                        r_acc <= acc_n;
                        if (r_ridx == LAST) begin
                            r_state <= S_PMUL;
                        end
                    end
                end
                S_PMUL: begin
                    r_pprod <= PW'(r_frac) * PW'(r_sum);
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (r_pend) begin
                        r_acc <= acc_n;
                        if (hit || r_ridx == LAST) begin
                            r_chosen <= r_ridx;
                            r_cnt    <= '0;
                            r_pend   <= 1'b0;
                            r_state  <= S_MAX;
                        end
                    end
                end
                // largest row count, then the result word
                S_MAX: begin
                    if (r_pend) begin
                        r_max <= max_n;
                        if (r_ridx == LAST) begin
                            o_valid             <= 1'b1;
                            o_chosen_row        <= chosen_x[2:0];
                            o_max_active_docs   <= (r_inv == 8'd0) ? max_n : '0;
                            o_docs_valid        <= (r_inv == 8'd0);
                            o_total_active_docs <= r_total;
                            r_state             <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // configuration writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DECAY) begin
                    r_decay <= i_cfg_data[QC_W-1:0];
                end else begin
                    r_init  <= i_cfg_data;
                    r_tval  <= '0;
                    r_stale <= 1'b1;
                end
            end
        end
    end

    lwrp_ram #(.W($bits(t_trow)), .D(NUM_ROWS)) u_tmem (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_raddr),
        .i_wdata (t_wdata),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_q_raw)
    );

    lwrp_ram #(.W(DOCS_W), .D(NUM_ROWS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_raddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_q)
    );

    lwrp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // checks
    a_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result shown while still in work");
    a_out_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_max_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_docs_valid || o_max_active_docs == '0))
        else $error("max count reported while counts invalid");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_rsp.busy)
        else $error("divider running while idle");
endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
    import lwrp_pkg::*;

    // no package constant exists for the do-nothing command
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int NROWS = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int RAND_ITEMS = 250;

    typedef struct packed {
        logic [2:0]  chosen;
        logic [39:0] max_docs;
        logic        docs_ok;
        logic [42:0] total;
    } t_answer;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  row;
        logic [31:0] sample;
        logic [15:0] frac;
        logic [39:0] new_cnt;
        logic        new_ok;
        logic [39:0] old_cnt;
        logic        old_ok;
        logic        typed;
        t_answer     ans;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = '0;
    logic [2:0]  i_row = '0;
    logic [31:0] i_sample_time = '0;
    logic [15:0] i_pick_fraction = '0;
    logic [39:0] i_new_count = '0;
    logic        i_new_valid = 1'b0;
    logic [39:0] i_old_count = '0;
    logic        i_old_valid = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic [2:0]  o_chosen_row;
    logic [39:0] o_max_active_docs;
    logic        o_docs_valid;
    logic [42:0] o_total_active_docs;

    latency_weighted_row_picker #(.NUM_ROWS(NROWS)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state of the picker
    logic [15:0] decay_reg;
    logic [31:0] init_reg;
    logic [31:0] avg_time [NROWS];
    logic [15:0] qcount [NROWS];
    logic [39:0] docs [NROWS];
    logic        row_ok [NROWS];
    logic [42:0] docs_sum;
    logic [7:0]  bad_rows;

    t_answer answers_due[$];
    int      errors = 0;
    int      idle_pct = 0;

    task automatic reload_averages();
        for (int i = 0; i < NROWS; i++) begin
            avg_time[i] = (init_reg < MIN_TIME) ? MIN_TIME : init_reg;
            qcount[i] = '0;
        end
    endtask

    function automatic logic [63:0] row_weight(int r);
        logic [63:0] a;
        a = (avg_time[r] == 0) ? 64'd1 : 64'(avg_time[r]);
        return (64'd1 << 32) / a;
    endfunction

    // advance the model by one command word and return its result
    function automatic t_answer fold_command(t_word w);
        t_answer a;
        logic [63:0] lim, dv, smp, acc, tot;
        int r;
        a = '0;
        r = w.row;
        case (w.cmd)
            CMD_TIME: begin
                lim = (decay_reg < MIN_DIV) ? 64'(MIN_DIV) : 64'(decay_reg);
                dv = 64'(qcount[r]) + 64'(MIN_DIV);
                if (dv > lim) dv = lim;
                smp = (w.sample < MIN_TIME) ? 64'(MIN_TIME) : 64'(w.sample);
                avg_time[r] = 32'((smp + (dv - 1) * 64'(avg_time[r])) / dv);
                if (qcount[r] != QC_MAX) qcount[r]++;
            end
            CMD_PICK: begin
                tot = 0;
                acc = 0;
                for (int i = 0; i < NROWS; i++) tot += row_weight(i);
                a.chosen = 3'(NROWS - 1);
                for (int i = 0; i + 1 < NROWS; i++) begin
                    acc += row_weight(i);
                    if (64'(w.frac) * tot < (acc << 16)) begin
                        a.chosen = 3'(i);
                        break;
                    end
                end
            end
            CMD_DOCS: begin
                docs_sum = docs_sum + 43'(w.new_cnt) - 43'(w.old_cnt);
                docs[r] = docs[r] + w.new_cnt - w.old_cnt;
                row_ok[r] = w.new_ok;
                if (w.new_ok != w.old_ok) begin
                    if (w.old_ok) begin
                        if (bad_rows != INV_MAX) bad_rows++;
                    end else if (bad_rows != 0) begin
                        bad_rows--;
                    end
                end
            end
            default: ;
        endcase
        a.docs_ok = (bad_rows == 0);
        if (a.docs_ok)
            for (int i = 0; i < NROWS; i++)
                if (docs[i] > a.max_docs) a.max_docs = docs[i];
        a.total = docs_sum;
        return a;
    endfunction

    // present one word and hold it until taken
    task automatic issue(t_word w);
        t_answer a;
        i_command <= w.cmd;
        i_row <= w.row;
        i_sample_time <= w.sample;
        i_pick_fraction <= w.frac;
        i_new_count <= w.new_cnt;
        i_new_valid <= w.new_ok;
        i_old_count <= w.old_cnt;
        i_old_valid <= w.old_ok;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        a = fold_command(w);
        answers_due.push_back(w.typed ? w.ans : a);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0 || busy);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic idx, logic [31:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DECAY) begin
            decay_reg = data[15:0];
        end else begin
            init_reg = data;
            reload_averages();
        end
    endtask

    function automatic t_word random_word();
        t_word w;
        int r;
        w = '0;
        r = $urandom_range(NROWS - 1);
        w.row = 3'(r);
        w.frac = 16'($urandom);
        case ($urandom_range(9))
            0, 1, 2, 3: w.cmd = CMD_TIME;
            4, 5, 6:    w.cmd = CMD_PICK;
            7, 8:       w.cmd = CMD_DOCS;
            default:    w.cmd = CMD_NOP;
        endcase
        // mostly realistic latencies, some wild ones
        case ($urandom_range(3))
            0:       w.sample = $urandom;
            1:       w.sample = $urandom_range(200);
            default: w.sample = $urandom_range(32'h4_0000);
        endcase
        w.new_cnt = ($urandom_range(3) == 0) ? 40'({$urandom, $urandom})
                                             : 40'($urandom_range(5000));
        w.new_ok = ($urandom_range(7) != 0);
        // well-formed updates retire the row's own previous count
        if ($urandom_range(4) != 0) begin
            w.old_cnt = docs[r];
            w.old_ok = row_ok[r];
        end else begin
            w.old_cnt = 40'({$urandom, $urandom});
            w.old_ok = 1'($urandom);
        end
        return w;
    endfunction

    // result checking and stall watchdog
    int stall = 0;
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n) begin
            if (o_valid || (start && !busy)) stall = 0;
            else stall++;
            if (stall >= STALL_LIMIT) begin
                $display("** latency_weighted_row_picker: FAILED **");
                $finish;
            end
            if (o_valid) begin
                if (answers_due.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    e = answers_due.pop_front();
                    if (o_chosen_row !== e.chosen) begin
                        $error("chosen_row exp %0d got %0d", e.chosen, o_chosen_row);
                        errors++;
                    end
                    if (o_max_active_docs !== e.max_docs) begin
                        $error("max_active_docs exp %0h got %0h", e.max_docs,
                               o_max_active_docs);
                        errors++;
                    end
                    if (o_docs_valid !== e.docs_ok) begin
                        $error("docs_valid exp %0d got %0d", e.docs_ok, o_docs_valid);
                        errors++;
                    end
                    if (o_total_active_docs !== e.total) begin
                        $error("total_active_docs exp %0h got %0h", e.total,
                               o_total_active_docs);
                        errors++;
                    end
                end
            end
        end
    end

    // directed words: cmd, row, sample, frac, new, nv, old, ov, typed, answer
    t_word directed [] = '{
        '{CMD_PICK, 3'd0, 32'd0, 16'h0000, 40'd0, 1'b0, 40'd0, 1'b0, 1'b1,
          '{3'd0, 40'd0, 1'b1, 43'd0}},
        '{CMD_PICK, 3'd0, 32'd0, 16'hFFFF, 40'd0, 1'b0, 40'd0, 1'b0, 1'b1,
          '{3'd7, 40'd0, 1'b1, 43'd0}},
        '{CMD_NOP, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 40'hFF_FFFF_FFFF, 1'b1,
          40'hFF_FFFF_FFFF, 1'b1, 1'b1, '{3'd0, 40'd0, 1'b1, 43'd0}},
        '{CMD_TIME, 3'd2, 32'd0, 16'd0, 40'd0, 1'b0, 40'd0, 1'b0, 1'b0, '0},
        '{CMD_TIME, 3'd5, 32'hFFFF_FFFF, 16'd0, 40'd0, 1'b0, 40'd0, 1'b0, 1'b0, '0},
        '{CMD_TIME, 3'd7, 32'd66, 16'd0, 40'd0, 1'b0, 40'd0, 1'b0, 1'b0, '0},
        '{CMD_PICK, 3'd0, 32'd0, 16'h8000, 40'd0, 1'b0, 40'd0, 1'b0, 1'b0, '0},
        '{CMD_PICK, 3'd0, 32'd0, 16'h0000, 40'd0, 1'b0, 40'd0, 1'b0, 1'b0, '0},
        '{CMD_PICK, 3'd0, 32'd0, 16'hFFFF, 40'd0, 1'b0, 40'd0, 1'b0, 1'b0, '0},
        // a row turning invalid hides the maximum
        '{CMD_DOCS, 3'd3, 32'd0, 16'd0, 40'd5, 1'b0, 40'd0, 1'b1, 1'b1,
          '{3'd0, 40'd0, 1'b0, 43'd5}},
        '{CMD_DOCS, 3'd3, 32'd0, 16'd0, 40'd0, 1'b1, 40'd0, 1'b0, 1'b1,
          '{3'd0, 40'd5, 1'b1, 43'd5}},
        // invalid counter already at zero stays there
        '{CMD_DOCS, 3'd6, 32'd0, 16'd0, 40'd1, 1'b1, 40'd0, 1'b0, 1'b1,
          '{3'd0, 40'd5, 1'b1, 43'd6}},
        '{CMD_DOCS, 3'd0, 32'd0, 16'd0, 40'hFF_FFFF_FFFF, 1'b1, 40'd0, 1'b1, 1'b0, '0},
        // a row count wraps below zero
        '{CMD_DOCS, 3'd0, 32'd0, 16'd0, 40'd0, 1'b1, 40'd2, 1'b1, 1'b0, '0},
        '{CMD_DOCS, 3'd1, 32'd0, 16'd0, 40'd3, 1'b1, 40'hFF_FFFF_FFFF, 1'b1, 1'b0, '0},
        '{CMD_DOCS, 3'd4, 32'd0, 16'd0, 40'd9, 1'b0, 40'd0, 1'b1, 1'b0, '0},
        '{CMD_DOCS, 3'd4, 32'd0, 16'd0, 40'd0, 1'b1, 40'd9, 1'b0, 1'b0, '0},
        '{CMD_NOP, 3'd0, 32'd0, 16'd0, 40'd0, 1'b0, 40'd0, 1'b0, 1'b0, '0}
    };

    logic [15:0] decay_set [3] = '{16'd0, 16'd65535, 16'd42};
    logic [31:0] init_set [3] = '{32'd0, 32'hFFFF_FFFF, 32'd66};

    initial begin
        decay_reg = 16'd1000;
        init_reg = 32'd65536;
        reload_averages();
        for (int i = 0; i < NROWS; i++) begin
            docs[i] = '0;
            row_ok[i] = 1'b1;
        end
        docs_sum = '0;
        bad_rows = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) issue(directed[k]);

        // three phases: sender idles 31%, then 50%, then never
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 31 : (ph == 1) ? 50 : 0;
            write_reg(CFG_DECAY, 32'(decay_set[ph]));
            write_reg(CFG_INIT, init_set[ph]);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (n == RAND_ITEMS / 2) begin
                    drain();
                    write_reg(CFG_DECAY, $urandom_range(42, 3000));
                    write_reg(CFG_INIT, $urandom_range(66, 32'h10_0000));
                end
                issue(random_word());
            end
        end

        drain();
        repeat (150) @(posedge i_clk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("** latency_weighted_row_picker: PASSED **");
        end else begin
            $display("** latency_weighted_row_picker: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ latency_weighted_row_picker.f @@
hw/rtl/lwrp_pkg.sv
hw/rtl/lwrp_ram.sv
hw/rtl/lwrp_div.sv
hw/rtl/latency_weighted_row_picker.sv
test/tb.sv
